/* src/mcl_pkg.sv */
// shared types and constants of the looping clip recorder and player
package mcl_pkg;

	localparam int MAX_NOTES = 64;
	localparam int IDX_W     = $clog2(MAX_NOTES);
	localparam int CNT_W     = $clog2(MAX_NOTES + 1);
	localparam int PITCH_W   = 7;
	localparam int PITCH_N   = 1 << PITCH_W;
	localparam int CLIP_W    = 24;
	localparam int TICK_W    = 32;
	localparam int Q_DEPTH   = 2;
	localparam int QP_W      = $clog2(Q_DEPTH);
	localparam int QC_W      = $clog2(Q_DEPTH + 1);

	localparam logic [6:0] PITCH_MAX = 7'd127;
	localparam logic [23:0] QUANT_MIN = 24'd3;

	// input action codes
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_ON   = 2'd1;
	localparam logic [1:0] ACT_OFF  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_TPS       = 3'd0;
	localparam logic [2:0] REG_STEPS     = 3'd1;
	localparam logic [2:0] REG_QUANT     = 3'd2;
	localparam logic [2:0] REG_STRETCH   = 3'd3;
	localparam logic [2:0] REG_SCROLL    = 3'd4;
	localparam logic [2:0] REG_TRANSPOSE = 3'd5;
	localparam logic [2:0] REG_ARMED     = 3'd6;
	localparam logic [2:0] REG_MUTED     = 3'd7;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_ON,
		CMD_OFF
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [TICK_W-1:0]  tick;
		logic [PITCH_W-1:0] pitch;
		logic [6:0]         vel;
	} cmd_t;

	typedef struct packed {
		logic [7:0]         tps;
		logic [15:0]        steps;
		logic [23:0]        quant;
		logic [7:0]         stretch;
		logic signed [15:0] scroll;
		logic signed [7:0]  transpose;
		logic               armed;
		logic               muted;
	} cfg_t;

	typedef struct packed {
		logic [CLIP_W-1:0]  start;
		logic [TICK_W-1:0]  length;
		logic [PITCH_W-1:0] pitch;
		logic [6:0]         vel;
	} note_t;

endpackage

/* src/mcl_ram.sv */
// generic single-port-write ram with registered read
module mcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* src/mcl_mod.sv */
// serial remainder unit, one dividend bit per cycle
module mcl_mod (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [mcl_pkg::TICK_W-1:0] dividend,
	input  logic [mcl_pkg::CLIP_W-1:0] divisor,
	output logic                     done,
	output logic [mcl_pkg::CLIP_W-1:0] rem
);
	import mcl_pkg::*;

	logic                      run_q;
	logic [$clog2(TICK_W)-1:0] cnt_q;
	logic [TICK_W-1:0]         dvd_q;
	logic [CLIP_W-1:0]         rem_q;
	logic [CLIP_W-1:0]         dvs_q;
	logic [CLIP_W:0]           trial;
	logic [CLIP_W:0]           diff;

	always_comb begin
		trial = {rem_q, dvd_q[TICK_W-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= diff[CLIP_W] ? trial[CLIP_W-1:0] : diff[CLIP_W-1:0];
		end
	end

	assign rem = rem_q;
endmodule

/* src/mcl_queue.sv */
// short command queue between front and back
module mcl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mcl_pkg::cmd_t push_cmd,
	input  logic          pop,
	output mcl_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);
	import mcl_pkg::*;

	cmd_t            mem_q [Q_DEPTH];
	logic [QP_W-1:0] wr_q;
	logic [QP_W-1:0] rd_q;
	logic [QC_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	assign head  = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QC_W'(Q_DEPTH));
endmodule

/* src/mcl_front.sv */
// accepts items and sorts them into tick, note on and note off commands
module mcl_front (
	input  logic                       start,
	input  logic [1:0]                 action,
	input  logic [mcl_pkg::TICK_W-1:0] tick_count,
	input  logic [mcl_pkg::PITCH_W-1:0] pitch,
	input  logic [6:0]                 velocity,
	input  logic                       armed,
	input  logic                       q_full,
	output logic                       busy,
	output logic                       push,
	output mcl_pkg::cmd_t              cmd
);
	import mcl_pkg::*;

	logic keep;

	always_comb begin
		cmd.tick  = tick_count;
		cmd.pitch = pitch;
		cmd.vel   = velocity;
		cmd.kind  = CMD_TICK;
		keep      = 1'b0;
		case (action)
			ACT_TICK: begin
				keep = 1'b1;
			end
			ACT_ON: begin
				keep     = armed;
				cmd.kind = (velocity != '0) ? CMD_ON : CMD_OFF;
			end
			ACT_OFF: begin
				keep     = armed;
				cmd.kind = CMD_OFF;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign busy = q_full;
	assign push = start && !q_full && keep;
endmodule

/* src/mcl_back.sv */
// executes commands: note recording and the per-tick walk over stored notes
module mcl_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcl_pkg::cfg_t               cfg,
	input  logic                        q_empty,
	input  mcl_pkg::cmd_t               q_head,
	output logic                        q_pop,
	output logic                        strobe,
	output logic [mcl_pkg::PITCH_W-1:0] out_pitch,
	output logic [6:0]                  out_velocity,
	output logic [mcl_pkg::TICK_W-1:0]  off_tick,
	output logic                        last
);
	import mcl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BEGIN,
		S_POS_WAIT,
		S_NOTE_CMD,
		S_OFF_RD,
		S_OFF_WR,
		S_WALK,
		S_NOTE,
		S_CHK,
		S_SCR_WAIT,
		S_Q_WAIT,
		S_W_WAIT,
		S_MATCH,
		S_FLUSH
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [TICK_W-1:0]   cur_tick_q;
	logic [CLIP_W-1:0]   len_q;
	logic [CLIP_W-1:0]   pos_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    walk_q;
	logic [PITCH_N-1:0]  held_valid_q;
	note_t               note_q;
	logic [27:0]         t_q;
	logic                neg_q;
	logic [CLIP_W-1:0]   s_q;
	logic [CLIP_W-1:0]   when_q;
	logic                pend_q;
	logic [PITCH_W-1:0]  pend_pitch_q;
	logic [6:0]          pend_vel_q;
	logic [TICK_W-1:0]   pend_off_q;

	logic                mod_go_q;
	logic [TICK_W-1:0]   mod_dvd_q;
	logic [CLIP_W-1:0]   mod_dvs_q;
	logic                mod_done;
	logic [CLIP_W-1:0]   mod_rem;

	logic                note_we;
	logic [IDX_W-1:0]    note_waddr;
	note_t               note_wdata;
	note_t               note_rdata;
	logic                held_we;
	logic [IDX_W-1:0]    held_rdata;

	logic [31:0]         prod;
	logic signed [29:0]  scr_v;
	logic [29:0]         scr_abs;
	logic [CLIP_W-1:0]   scr_s;
	logic [CLIP_W-1:0]   q_base;
	logic [CLIP_W:0]     q_wrap;
	logic signed [9:0]   tp_sum;
	logic [PITCH_W-1:0]  tp_pitch;
	logic signed [33:0]  off_d;
	logic signed [33:0]  off_len;
	logic                store_room;

	mcl_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (mod_go_q),
		.dividend (mod_dvd_q),
		.divisor  (mod_dvs_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	mcl_ram #(.WIDTH($bits(note_t)), .DEPTH(MAX_NOTES)) u_notes (
		.clk   (clk),
		.we    (note_we),
		.waddr (note_waddr),
		.wdata (note_wdata),
		.raddr (idx_q),
		.rdata (note_rdata)
	);

	mcl_ram #(.WIDTH(IDX_W), .DEPTH(PITCH_N)) u_held (
		.clk   (clk),
		.we    (held_we),
		.waddr (cmd_q.pitch),
		.wdata (count_q[IDX_W-1:0]),
		.raddr (cmd_q.pitch),
		.rdata (held_rdata)
	);

	always_comb begin
		store_room = (count_q < CNT_W'(MAX_NOTES));
		prod       = note_rdata.start * cfg.stretch;
		scr_v      = $signed({2'b00, t_q}) + 30'(cfg.scroll * 24);
		scr_abs    = scr_v[29] ? 30'(-scr_v) : scr_v;
		if (!neg_q) begin
			scr_s = mod_rem;
		end else if (mod_rem == '0) begin
			scr_s = '0;
		end else begin
			scr_s = len_q - mod_rem;
		end
		q_base   = s_q - mod_rem;
		q_wrap   = {1'b0, q_base} + {1'b0, cfg.quant};
		tp_sum   = $signed({3'b000, note_q.pitch}) + 10'(cfg.transpose);
		if (tp_sum < 0) begin
			tp_pitch = '0;
		end else if (tp_sum > $signed({3'b000, PITCH_MAX})) begin
			tp_pitch = PITCH_MAX;
		end else begin
			tp_pitch = tp_sum[PITCH_W-1:0];
		end
		// note length, zero becomes one and negatives wrap by the clip
		off_d   = $signed({10'd0, pos_q}) - $signed({10'd0, note_rdata.start});
		off_len = off_d;
		if (off_d == '0) begin
			off_len = 34'sd1;
		end else if (off_d < 0) begin
			off_len = off_d + $signed({10'd0, len_q});
		end
		note_we    = 1'b0;
		note_waddr = count_q[IDX_W-1:0];
		note_wdata = '{start: pos_q, length: '0, pitch: cmd_q.pitch, vel: cmd_q.vel};
		held_we    = 1'b0;
		if (state_q == S_NOTE_CMD && cmd_q.kind == CMD_ON && store_room) begin
			note_we = 1'b1;
			held_we = 1'b1;
		end else if (state_q == S_OFF_WR) begin
			note_we    = 1'b1;
			note_waddr = idx_q;
			note_wdata = note_rdata;
			note_wdata.length = off_len[TICK_W-1:0];
		end
	end

	assign q_pop = (state_q == S_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_tick_q   <= '0;
			count_q      <= '0;
			held_valid_q <= '0;
			pend_q       <= 1'b0;
			mod_go_q     <= 1'b0;
			strobe       <= 1'b0;
			last         <= 1'b0;
			len_q        <= '0;
		end else begin
			mod_go_q <= 1'b0;
			strobe   <= 1'b0;
			len_q    <= cfg.tps * cfg.steps;
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cmd_q   <= q_head;
						state_q <= S_BEGIN;
					end
				end
				S_BEGIN: begin
					mod_dvs_q <= len_q;
					if (cmd_q.kind == CMD_TICK) begin
						cur_tick_q <= cmd_q.tick;
						mod_dvd_q  <= cmd_q.tick;
						if (cfg.muted || len_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							mod_go_q <= 1'b1;
							state_q  <= S_POS_WAIT;
						end
					end else begin
						mod_dvd_q <= cur_tick_q;
						if (len_q == '0) begin
							pos_q   <= '0;
							state_q <= S_NOTE_CMD;
						end else begin
							mod_go_q <= 1'b1;
							state_q  <= S_POS_WAIT;
						end
					end
				end
				S_POS_WAIT: begin
					if (mod_done) begin
						pos_q <= mod_rem;
						if (cmd_q.kind == CMD_TICK) begin
							idx_q   <= '0;
							walk_q  <= '0;
							pend_q  <= 1'b0;
							state_q <= S_WALK;
						end else begin
							state_q <= S_NOTE_CMD;
						end
					end
				end
				S_NOTE_CMD: begin
					state_q <= S_IDLE;
					if (cmd_q.kind == CMD_ON) begin
						if (store_room) begin
							held_valid_q[cmd_q.pitch] <= 1'b1;
							count_q <= count_q + 1'b1;
						end
					end else begin
						held_valid_q[cmd_q.pitch] <= 1'b0;
						if (held_valid_q[cmd_q.pitch]) begin
							idx_q   <= held_rdata;
							state_q <= S_OFF_RD;
						end
					end
				end
				S_OFF_RD: begin
					state_q <= S_OFF_WR;
				end
				S_OFF_WR: begin
					state_q <= S_IDLE;
				end
				S_WALK: begin
					state_q <= (walk_q == count_q) ? S_FLUSH : S_NOTE;
				end
				S_NOTE: begin
					note_q <= note_rdata;
					t_q    <= prod[31:4];
					if (note_rdata.length == '0) begin
						idx_q   <= idx_q + 1'b1;
						walk_q  <= walk_q + 1'b1;
						state_q <= S_WALK;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (t_q >= {4'd0, len_q}) begin
						idx_q   <= idx_q + 1'b1;
						walk_q  <= walk_q + 1'b1;
						state_q <= S_WALK;
					end else begin
						neg_q     <= scr_v[29];
						mod_dvd_q <= {2'b00, scr_abs};
						mod_dvs_q <= len_q;
						mod_go_q  <= 1'b1;
						state_q   <= S_SCR_WAIT;
					end
				end
				S_SCR_WAIT: begin
					if (mod_done) begin
						s_q <= scr_s;
						if (cfg.quant >= QUANT_MIN) begin
							mod_dvd_q <= {8'd0, scr_s};
							mod_dvs_q <= cfg.quant;
							mod_go_q  <= 1'b1;
							state_q   <= S_Q_WAIT;
						end else begin
							when_q  <= scr_s;
							state_q <= S_MATCH;
						end
					end
				end
				S_Q_WAIT: begin
					if (mod_done) begin
						if (mod_rem > (cfg.quant >> 1)) begin
							mod_dvd_q <= {7'd0, q_wrap};
							mod_dvs_q <= len_q;
							mod_go_q  <= 1'b1;
							state_q   <= S_W_WAIT;
						end else begin
							when_q  <= q_base;
							state_q <= S_MATCH;
						end
					end
				end
				S_W_WAIT: begin
					if (mod_done) begin
						when_q  <= mod_rem;
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					if (when_q == pos_q) begin
						// the held result is not the final one: send it now
						if (pend_q) begin
							strobe       <= 1'b1;
							last         <= 1'b0;
							out_pitch    <= pend_pitch_q;
							out_velocity <= pend_vel_q;
							off_tick     <= pend_off_q;
						end
						pend_q       <= 1'b1;
						pend_pitch_q <= tp_pitch;
						pend_vel_q   <= note_q.vel;
						pend_off_q   <= cur_tick_q + note_q.length;
					end
					idx_q   <= idx_q + 1'b1;
					walk_q  <= walk_q + 1'b1;
					state_q <= S_WALK;
				end
				S_FLUSH: begin
					if (pend_q) begin
						strobe       <= 1'b1;
						last         <= 1'b1;
						out_pitch    <= pend_pitch_q;
						out_velocity <= pend_vel_q;
						off_tick     <= pend_off_q;
					end
					pend_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

/* src/midi_clip_loop_recorder_player_top.sv */
// top level of the looping note clip recorder and player
// Items go in with start while busy is low; busy rises only when the two-entry
// command queue is full. A tick item first finds its clip position, then walks
// the stored notes, up to 64: each note with nonzero length may run up to three
// remainders through the one shared serial remainder unit for its placement.
// Results come out at most one per cycle, each held for one cycle and marked by
// strobe; the receiver cannot stall them. last marks the final result of a tick.
// Ticks that are muted, note items and action 3 give no results. Configuration
// is to be written with cfg_we only while the block is idle; the block itself
// does not enforce this.
module midi_clip_loop_recorder_player_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] tick_count,
	input  logic [6:0]  pitch,
	input  logic [6:0]  velocity,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output logic        strobe,
	output logic [6:0]  out_pitch,
	output logic [6:0]  out_velocity,
	output logic [31:0] off_tick,
	output logic        last
);
	import mcl_pkg::*;

	cfg_t cfg_q;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tps       <= 8'd24;
			cfg_q.steps     <= 16'd64;
			cfg_q.quant     <= 24'd1;
			cfg_q.stretch   <= 8'd16;
			cfg_q.scroll    <= '0;
			cfg_q.transpose <= '0;
			cfg_q.armed     <= 1'b0;
			cfg_q.muted     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TPS:       cfg_q.tps       <= cfg_data[7:0];
				REG_STEPS:     cfg_q.steps     <= cfg_data[15:0];
				REG_QUANT:     cfg_q.quant     <= cfg_data;
				REG_STRETCH:   cfg_q.stretch   <= cfg_data[7:0];
				REG_SCROLL:    cfg_q.scroll    <= cfg_data[15:0];
				REG_TRANSPOSE: cfg_q.transpose <= cfg_data[7:0];
				REG_ARMED:     cfg_q.armed     <= cfg_data[0];
				REG_MUTED:     cfg_q.muted     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// front: takes each transfer and sorts it
	mcl_front u_front (
		.start      (start),
		.action     (action),
		.tick_count (tick_count),
		.pitch      (pitch),
		.velocity   (velocity),
		.armed      (cfg_q.armed),
		.q_full     (q_full),
		.busy       (busy),
		.push       (q_push),
		.cmd        (push_cmd)
	);

	mcl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// back: recording and playback walk
	mcl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.strobe       (strobe),
		.out_pitch    (out_pitch),
		.out_velocity (out_velocity),
		.off_tick     (off_tick),
		.last         (last)
	);

`ifndef NO_ASSERTIONS
	// the final result of a tick is never followed at once by another
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result right after final result");
	// every played result has nonzero velocity, as only such notes are recorded
	a_vel_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> out_velocity != 7'd0)
		else $error("played note with zero velocity");
	// nothing is popped from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");
`endif
endmodule
